>>> rtl/bcs_pkg.sv
// ============================================================================
// bcs_pkg: shared types and constants for the burst channel scheduler
// Payload structs, configuration register indexes, reset values and the
// command/status bundles between controller and datapath.
// ============================================================================
package bcs_pkg;

    localparam int MAX_CHANNELS_DEF = 16;
    localparam int TIME_BITS_DEF    = 32;

    localparam int FIELD_TIME_W = 32;
    localparam int CHAN_W       = 4;
    localparam int ACTIVE_W     = 5;
    localparam int CONTROL_W    = 4;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL = 1'b1;

    localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = 5'd16;
    localparam logic [CONTROL_W-1:0] CONTROL_RESET = 4'd1;

    // request kinds
    localparam logic FUNC_CONTROL = 1'b0;
    localparam logic FUNC_DATA    = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [FIELD_TIME_W-1:0] arrival_time;
        logic [FIELD_TIME_W-1:0] burst_length;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic [CHAN_W-1:0]       channel_index;
        logic [FIELD_TIME_W-1:0] start_time;
        logic                    in_void;
    } res_t;

    typedef struct packed {
        logic load;     // latch the request, set up the first pass
        logic issue;    // read the next channel entry
        logic restart;  // begin the latest-available pass
        logic commit;   // write back the chosen channel
        logic post;     // load the output register
    } cmd_t;

    typedef struct packed {
        logic skip;       // nothing to scan or a zero-length data burst, drop the request
        logic last;       // the current read is the last of the pass
        logic have;       // a channel qualified in this pass
        logic void_mode;  // the pass looks at voids
    } sts_t;

endpackage

>>> rtl/bcs_ram.sv
// ============================================================================
// bcs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
module bcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bcs_dp.sv
// ============================================================================
// bcs_dp: scheduler datapath
// Configuration registers, channel table with per-row valid bits, scan
// compare/select unit, write-back update and the output register.
// ============================================================================
module bcs_dp
    import bcs_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  req_t                   req,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output res_t                   res
);

    localparam int IDX_W     = $clog2(MAX_CHANNELS);
    localparam int CNT_RAW_W = $clog2(MAX_CHANNELS + 1);
    localparam int CNT_W     = (CNT_RAW_W > ACTIVE_W) ? CNT_RAW_W : ACTIVE_W;
    localparam int ROW_W     = 3 * TIME_BITS;

    // configuration
    logic [ACTIVE_W-1:0]  active_reg, active_next;
    logic [CONTROL_W-1:0] control_reg, control_next;

    // request context
    logic                 kind_reg, kind_next;
    logic [TIME_BITS-1:0] t_reg, t_next;
    logic [TIME_BITS-1:0] d_reg, d_next;
    logic [TIME_BITS-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic                 skip_reg, skip_next;

    // scan state
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    void_mode_reg, void_mode_next;
    logic                    eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]        eval_idx_reg, eval_idx_next;
    logic                    eval_ok_reg, eval_ok_next;
    logic                    have_reg, have_next;
    logic [TIME_BITS-1:0]    best_gap_reg, best_gap_next;
    logic [IDX_W-1:0]        ch_reg, ch_next;
    logic [TIME_BITS-1:0]    best_busy_reg, best_busy_next;
    logic [TIME_BITS-1:0]    best_vb_reg, best_vb_next;
    logic [TIME_BITS-1:0]    best_vf_reg, best_vf_next;
    logic [MAX_CHANNELS-1:0] row_valid_reg, row_valid_next;
    res_t                    res_reg, res_next;

    // combinational helpers
    logic [CNT_W-1:0]     act_ext, ctl_ext, act_eff, ctl_eff, lo_in, hi_in;
    logic [TIME_BITS-1:0] t_in, d_in;
    logic [TIME_BITS:0]   sum_wide;
    logic [ROW_W-1:0]     rd_data, wr_data;
    logic [TIME_BITS-1:0] e_busy, e_vb, e_vf;
    logic                 void_fit, busy_fit, fit;
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS-1:0] new_busy, new_vb, new_vf;
    logic                 wr_en;

    always_comb
    begin
        act_ext = CNT_W'(active_reg);
        ctl_ext = CNT_W'(control_reg);
        act_eff = (act_ext > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : act_ext;
        ctl_eff = (ctl_ext < act_eff) ? ctl_ext : act_eff;
        t_in    = TIME_BITS'(req.arrival_time);
        d_in    = TIME_BITS'(req.burst_length);
        lo_in   = (req.func == FUNC_DATA) ? ctl_eff : '0;
        hi_in   = (req.func == FUNC_DATA) ? act_eff : ctl_eff;
        sum_wide = {1'b0, t_in} + {1'b0, d_in};
    end

    // row fields of the entry under evaluation; a never-written row reads zero
    always_comb
    begin
        e_busy = eval_ok_reg ? rd_data[3*TIME_BITS-1:2*TIME_BITS] : '0;
        e_vb   = eval_ok_reg ? rd_data[2*TIME_BITS-1:TIME_BITS] : '0;
        e_vf   = eval_ok_reg ? rd_data[TIME_BITS-1:0] : '0;

        void_fit = (t_reg >= e_vb) && (e_vf >= t_reg) && ((e_vf - t_reg) >= d_reg);
        busy_fit = (t_reg >= e_busy);
        fit      = void_mode_reg ? void_fit : busy_fit;
        gap      = void_mode_reg ? (t_reg - e_vb) : (t_reg - e_busy);
    end

    // write-back values for the chosen channel
    always_comb
    begin
        new_busy = best_busy_reg;
        new_vb   = best_vb_reg;
        new_vf   = best_vf_reg;
        if (kind_reg == FUNC_CONTROL)
        begin
            new_busy = sum_reg;
        end
        else if (t_reg == best_busy_reg)
        begin
            new_busy = sum_reg;
        end
        else if (t_reg > best_busy_reg)
        begin
            // open a void between the old tail and this burst
            new_vb   = best_busy_reg;
            new_vf   = t_reg;
            new_busy = sum_reg;
        end
        else
        begin
            // shrink the void from the front
            new_vb = sum_reg;
        end
        wr_data = {new_busy, new_vb, new_vf};
        wr_en   = cmd.commit && have_reg;
    end

    always_comb
    begin
        active_next     = active_reg;
        control_next    = control_reg;
        kind_next       = kind_reg;
        t_next          = t_reg;
        d_next          = d_reg;
        sum_next        = sum_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        skip_next       = skip_reg;
        idx_next        = idx_reg;
        void_mode_next  = void_mode_reg;
        eval_valid_next = cmd.issue;
        eval_idx_next   = idx_reg[IDX_W-1:0];
        eval_ok_next    = row_valid_reg[idx_reg[IDX_W-1:0]];
        have_next       = have_reg;
        best_gap_next   = best_gap_reg;
        ch_next         = ch_reg;
        best_busy_next  = best_busy_reg;
        best_vb_next    = best_vb_reg;
        best_vf_next    = best_vf_reg;
        row_valid_next  = row_valid_reg;
        res_next        = res_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTIVE:  active_next  = cfg_data;
                REG_CONTROL: control_next = cfg_data[CONTROL_W-1:0];
                default:     ;
            endcase
        end

        if (cmd.load)
        begin
            kind_next      = req.func;
            t_next         = t_in;
            d_next         = d_in;
            sum_next       = sum_wide[TIME_BITS] ? '1 : sum_wide[TIME_BITS-1:0];
            lo_next        = lo_in;
            hi_next        = hi_in;
            skip_next      = (lo_in >= hi_in) || ((req.func == FUNC_DATA) && (d_in == '0));
            idx_next       = lo_in;
            void_mode_next = (req.func == FUNC_DATA);
            have_next      = 1'b0;
        end

        if (cmd.issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end

        if (eval_valid_reg && fit && (!have_reg || (gap < best_gap_reg)))
        begin
            have_next      = 1'b1;
            best_gap_next  = gap;
            ch_next        = eval_idx_reg;
            best_busy_next = e_busy;
            best_vb_next   = e_vb;
            best_vf_next   = e_vf;
        end

        if (cmd.restart)
        begin
            idx_next       = lo_reg;
            void_mode_next = 1'b0;
            have_next      = 1'b0;
        end

        if (wr_en)
        begin
            row_valid_next[ch_reg] = 1'b1;
        end

        if (cmd.post)
        begin
            res_next.found         = have_reg;
            res_next.channel_index = have_reg ? CHAN_W'(ch_reg) : '0;
            res_next.start_time    = have_reg ? FIELD_TIME_W'(t_reg) : '0;
            res_next.in_void       = have_reg && void_mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= ACTIVE_RESET;
            control_reg    <= CONTROL_RESET;
            kind_reg       <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            skip_reg       <= 1'b0;
            idx_reg        <= '0;
            void_mode_reg  <= 1'b0;
            eval_valid_reg <= 1'b0;
            have_reg       <= 1'b0;
            row_valid_reg  <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            control_reg    <= control_next;
            kind_reg       <= kind_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            skip_reg       <= skip_next;
            idx_reg        <= idx_next;
            void_mode_reg  <= void_mode_next;
            eval_valid_reg <= eval_valid_next;
            have_reg       <= have_next;
            row_valid_reg  <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        d_reg         <= d_next;
        sum_reg       <= sum_next;
        eval_idx_reg  <= eval_idx_next;
        eval_ok_reg   <= eval_ok_next;
        best_gap_reg  <= best_gap_next;
        ch_reg        <= ch_next;
        best_busy_reg <= best_busy_next;
        best_vb_reg   <= best_vb_next;
        best_vf_reg   <= best_vf_next;
        res_reg       <= res_next;
    end

    bcs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_CHANNELS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ch_reg),
        .wdata (wr_data),
        .re    (cmd.issue),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign sts.skip      = skip_reg;
    assign sts.last      = ((idx_reg + CNT_W'(1)) == hi_reg);
    assign sts.have      = have_reg;
    assign sts.void_mode = void_mode_reg;
    assign res           = res_reg;

    // a read never runs past the end of the pass range
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (idx_reg < hi_reg))
        else $error("scan read beyond pass range");

    // a posted hit names a channel of the range that was scanned
    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.post && have_reg) |->
            ((CNT_W'(ch_reg) >= lo_reg) && (CNT_W'(ch_reg) < hi_reg)))
        else $error("chosen channel outside pass range");

endmodule

>>> rtl/bcs_ctrl.sv
// ============================================================================
// bcs_ctrl: scheduler controller
// Sequences request intake, the void and latest-available scans, the
// write-back and the output register handshake.
// ============================================================================
module bcs_ctrl
    import bcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic res_valid,
    input  logic res_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_POST  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        cmd            = '0;
        req_ready      = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = sts.skip ? S_POST : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read data is evaluated this cycle
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (sts.void_mode && !sts.have)
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_SCAN;
                end
                else
                begin
                    cmd.commit = sts.have;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                // hold until the output register is free
                if (!res_valid_reg || res_ready)
                begin
                    cmd.post       = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

    a_commit_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.have)
        else $error("write-back without a chosen channel");

    a_post_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |=> res_valid_reg)
        else $error("posted result not presented");

endmodule

>>> rtl/burst_channel_scheduler_void_fill.sv
// ============================================================================
// burst_channel_scheduler_void_fill: burst channel scheduler with void filling
// Top level joining the controller, the datapath and its channel table.
//
// Requests enter on req (req_valid/req_ready): a control or data burst with
// arrival time and length. Each request yields exactly one result on res
// (res_valid/res_ready): found flag, channel, start time and void flag.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle:
// index 0 sets the active channel count, index 1 the control channel count.
//
// One request is in work at a time. With n channels in the scanned range a
// request reads n channel entries, or 2n when a data burst finds no void and
// the latest-available scan runs too; a dropped request with nothing to scan
// reads none and goes straight to posting its result. The table scan reads
// one channel entry per cycle from a single-read-port RAM.
//
// Reset sets 16 active channels and 1 control channel and marks every table
// row as unwritten, which reads as all-zero times; no clearing pass is run.
// A stalled receiver holds the result in the output register; the next
// request is still taken and scanned and waits only to post its result.
// ============================================================================
module burst_channel_scheduler_void_fill
    import bcs_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  req_t                   req,
    input  logic                   req_valid,
    output logic                   req_ready,
    output res_t                   res,
    output logic                   res_valid,
    input  logic                   res_ready,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    bcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bcs_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .TIME_BITS    (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .res       (res)
    );

endmodule

>>> sim/bcs_schedule_checker.sv
// ============================================================================
// bcs_schedule_checker: result checker for the burst channel scheduler
// Watches the request, result and register channels, keeps its own channel
// table and register copy, predicts the grant for every accepted request and
// compares each accepted result against the oldest prediction.
// ============================================================================
module bcs_schedule_checker
    import bcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  req_t                   req,
    input  logic                   req_valid,
    input  logic                   req_ready,
    input  res_t                   res,
    input  logic                   res_valid,
    input  logic                   res_ready,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     pending,
    output int                     checked,
    output int                     void_fills,
    output int                     drops
);

    localparam int CHANNELS = MAX_CHANNELS_DEF;

    logic [FIELD_TIME_W-1:0] free_at   [CHANNELS];
    logic [FIELD_TIME_W-1:0] gap_open  [CHANNELS];
    logic [FIELD_TIME_W-1:0] gap_close [CHANNELS];
    logic [ACTIVE_W-1:0]     active_cnt;
    logic [CONTROL_W-1:0]    control_cnt;
    res_t                    expected_grants [$];
    int                      err_count;
    int                      check_count;
    int                      fill_count;
    int                      drop_count;

    // channel in [lo, hi) free at t with the smallest idle gap, lowest index on ties
    task automatic pick_latest(input int lo, input int hi, input logic [FIELD_TIME_W-1:0] t,
                               output logic have, output int ch);
        logic [FIELD_TIME_W-1:0] gap;
        logic [FIELD_TIME_W-1:0] best;
        have = 1'b0;
        ch   = 0;
        best = '0;
        for (int i = lo; i < hi; i++)
        begin
            if (t >= free_at[i])
            begin
                gap = t - free_at[i];
                if (!have || gap < best)
                begin
                    have = 1'b1;
                    best = gap;
                    ch   = i;
                end
            end
        end
    endtask

    task automatic schedule_burst(input req_t r, output res_t grant);
        logic [FIELD_TIME_W-1:0] t;
        logic [FIELD_TIME_W-1:0] d;
        logic [FIELD_TIME_W-1:0] finish;
        logic [FIELD_TIME_W-1:0] gap;
        logic [FIELD_TIME_W-1:0] best;
        logic [FIELD_TIME_W:0]   wide;
        logic                    have;
        logic                    filled;
        int                      n_act;
        int                      n_ctl;
        int                      ch;
        t      = r.arrival_time;
        d      = r.burst_length;
        wide   = {1'b0, t} + {1'b0, d};
        finish = wide[FIELD_TIME_W] ? '1 : wide[FIELD_TIME_W-1:0];
        n_act  = (active_cnt > CHANNELS) ? CHANNELS : int'(active_cnt);
        n_ctl  = (int'(control_cnt) < n_act) ? int'(control_cnt) : n_act;
        have   = 1'b0;
        filled = 1'b0;
        ch     = 0;
        best   = '0;
        if (r.func == FUNC_CONTROL)
        begin
            pick_latest(0, n_ctl, t, have, ch);
            if (have)
                free_at[ch] = finish;
        end
        else if (d != '0)
        begin
            // try the recorded voids first, smallest leading gap wins
            for (int i = n_ctl; i < n_act; i++)
            begin
                if (t >= gap_open[i] && gap_close[i] >= t && gap_close[i] - t >= d)
                begin
                    gap = t - gap_open[i];
                    if (!have || gap < best)
                    begin
                        have = 1'b1;
                        best = gap;
                        ch   = i;
                    end
                end
            end
            filled = have;
            if (!have)
                pick_latest(n_ctl, n_act, t, have, ch);
            if (have)
            begin
                if (t == free_at[ch])
                    free_at[ch] = finish;
                else if (t > free_at[ch])
                begin
                    gap_open[ch]  = free_at[ch];
                    gap_close[ch] = t;
                    free_at[ch]   = finish;
                end
                else
                    gap_open[ch] = finish;
            end
        end
        grant.found         = have;
        grant.channel_index = have ? CHAN_W'(ch) : '0;
        grant.start_time    = have ? t : '0;
        grant.in_void       = have && filled;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t grant;
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                free_at[i]   = '0;
                gap_open[i]  = '0;
                gap_close[i] = '0;
            end
            active_cnt  = ACTIVE_RESET;
            control_cnt = CONTROL_RESET;
            expected_grants.delete();
            err_count   = 0;
            check_count = 0;
            fill_count  = 0;
            drop_count  = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual found=%0b ch=%0d start=%h in_void=%0b",
                             $time, res.found, res.channel_index, res.start_time, res.in_void);
                end
                else
                begin
                    want = expected_grants.pop_front();
                    check_count++;
                    if (res.found !== want.found || res.channel_index !== want.channel_index ||
                        res.start_time !== want.start_time || res.in_void !== want.in_void)
                    begin
                        err_count++;
                        $display("%0t: result mismatch, expected found=%0b ch=%0d start=%h in_void=%0b, actual found=%0b ch=%0d start=%h in_void=%0b",
                                 $time, want.found, want.channel_index, want.start_time,
                                 want.in_void, res.found, res.channel_index, res.start_time,
                                 res.in_void);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                schedule_burst(req, grant);
                if (!grant.found)
                    drop_count++;
                if (grant.in_void)
                    fill_count++;
                expected_grants.push_back(grant);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_ACTIVE)
                    active_cnt = cfg_data[ACTIVE_W-1:0];
                else if (cfg_index == REG_CONTROL)
                    control_cnt = cfg_data[CONTROL_W-1:0];
            end
        end
        errors     <= err_count;
        pending    <= expected_grants.size();
        checked    <= check_count;
        void_fills <= fill_count;
        drops      <= drop_count;
    end

endmodule

>>> sim/burst_channel_scheduler_void_fill_tb.sv
// ============================================================================
// burst_channel_scheduler_void_fill_tb: testbench for the channel scheduler
// Drives directed and random control/data bursts under several channel
// splits, with random idling on both channels and two long receiver stalls;
// the checker beside the block predicts and compares every result.
// ============================================================================
module burst_channel_scheduler_void_fill_tb;
    import bcs_pkg::*;

    localparam int IDLE_GAP     = 50;    // longer than the slowest request
    localparam int HOLD_CYCLES  = 400;
    localparam int WATCHDOG_MAX = 3000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    req_t                   req       = '0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    res_t                   res;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int   errors;
    int   pending;
    int   checked;
    int   void_fills;
    int   drops;
    int   items_sent = 0;
    int   settings   = 0;
    int   hold_reqs  = 0;
    int   holds_done = 0;
    int   stuck      = 0;
    logic no_idle    = 1'b0;
    logic [FIELD_TIME_W-1:0] now_tick = '0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    burst_channel_scheduler_void_fill u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bcs_schedule_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .void_fills (void_fills),
        .drops      (drops)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_burst(input logic kind, input logic [FIELD_TIME_W-1:0] t,
                              input logic [FIELD_TIME_W-1:0] d);
        int   gap;
        req_t r;
        gap            = pick_gap();
        r.func         = kind;
        r.arrival_time = t;
        r.burst_length = d;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        items_sent++;
    endtask

    // drain every outstanding result, then let the block settle
    task automatic wait_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_channels(input logic [CFG_DATA_W-1:0] act, input logic [CFG_DATA_W-1:0] ctl);
        wait_quiet();
        write_cfg(REG_ACTIVE, act);
        write_cfg(REG_CONTROL, ctl);
        settings++;
    endtask

    task automatic run_phase(input int count);
        logic                    kind;
        logic [FIELD_TIME_W-1:0] t;
        logic [FIELD_TIME_W-1:0] d;
        int                      sel;
        for (int k = 0; k < count; k++)
        begin
            kind     = ($urandom_range(0, 99) < 35) ? FUNC_CONTROL : FUNC_DATA;
            sel      = $urandom_range(0, 99);
            now_tick = now_tick + $urandom_range(0, 60);
            if (sel < 5)
            begin
                t = $urandom;
                d = $urandom;
            end
            else if (sel < 9)
            begin
                t = now_tick;
                d = '0;
            end
            else if (sel < 12)
            begin
                t = '1 - $urandom_range(0, 500);
                d = (sel == 11) ? ('1 - $urandom_range(0, 3)) : $urandom_range(0, 1000);
            end
            else
            begin
                // reach back into older voids now and then
                if ($urandom_range(0, 2) == 0)
                    t = now_tick - $urandom_range(0, 3000);
                else
                    t = now_tick + $urandom_range(0, 200);
                d = $urandom_range(1, 250);
            end
            send_burst(kind, t, d);
        end
    endtask

    // receiver: random back-pressure plus a long hold on request
    initial
    begin : receiver
        int n;
        @(posedge clk);
        forever
        begin
            if (holds_done != hold_reqs)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else if (no_idle)
            begin
                res_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    res_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                res_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= WATCHDOG_MAX)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_MAX);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int act;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset split: 16 channels, channel 0 for control
        send_burst(FUNC_CONTROL, 32'd0, 32'd0);           // zero-length control
        send_burst(FUNC_CONTROL, 32'd100, 32'd50);
        send_burst(FUNC_CONTROL, 32'd120, 32'd10);        // nothing free
        send_burst(FUNC_DATA, 32'd500, 32'd0);            // zero-length data
        send_burst(FUNC_DATA, 32'd1000, 32'd100);         // opens a void
        send_burst(FUNC_DATA, 32'd1000, 32'd100);
        send_burst(FUNC_DATA, 32'd200, 32'd300);          // void tie, lowest index
        send_burst(FUNC_DATA, 32'd600, 32'd400);          // exact void fit
        send_burst(FUNC_DATA, 32'd1100, 32'd50);          // lands on busy edge
        send_burst(FUNC_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_burst(FUNC_CONTROL, 32'hFFFF_FFFF, 32'd1);   // saturating sum
        send_burst(FUNC_DATA, 32'hAAAA_AAAA, 32'h5555_5555);
        send_burst(FUNC_DATA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_burst(FUNC_CONTROL, 32'h5555_5555, 32'hAAAA_AAAA);

        set_channels(5'd2, 5'd1);                         // one control and one data channel
        send_burst(FUNC_DATA, 32'h6000_0000, 32'd10);
        send_burst(FUNC_CONTROL, 32'hFFFF_FFFF, 32'd0);
        set_channels(5'd16, 5'd0);                        // no control channels
        send_burst(FUNC_CONTROL, 32'd5000, 32'd10);
        send_burst(FUNC_DATA, 32'd5000, 32'd10);
        set_channels(5'd31, 5'd15);                       // count capped, one data channel
        send_burst(FUNC_DATA, 32'h7000_0000, 32'd20);
        send_burst(FUNC_CONTROL, 32'h7000_0000, 32'd20);
        set_channels(5'd4, 5'd15);                        // control range past the end
        send_burst(FUNC_DATA, 32'h7100_0000, 32'd20);
        send_burst(FUNC_CONTROL, 32'h7100_0000, 32'd20);
        set_channels(5'd0, 5'd1);                         // nothing active
        send_burst(FUNC_CONTROL, 32'h7200_0000, 32'd5);
        send_burst(FUNC_DATA, 32'h7200_0000, 32'd5);

        set_channels(5'd16, 5'd1);
        now_tick = 32'h8000_0000;
        run_phase(100);

        set_channels(5'd16, 5'd15);
        hold_reqs <= hold_reqs + 1;                       // long stall, block fills up
        run_phase(80);

        set_channels(5'd2, 5'd1);
        no_idle <= 1'b1;
        run_phase(60);

        set_channels(5'd31, 5'd4);
        no_idle <= 1'b0;
        run_phase(80);

        set_channels(5'd16, 5'b10011);                    // upper bit dropped by the register
        run_phase(80);

        act = $urandom_range(2, 16);
        set_channels(CFG_DATA_W'(act), CFG_DATA_W'($urandom_range(1, act - 1)));
        hold_reqs <= hold_reqs + 1;
        run_phase(100);

        set_channels(5'd16, 5'd8);
        now_tick = 32'hFFFF_0000;                         // run up against saturation
        run_phase(100);

        wait_quiet();
        $display("Sent %0d requests over %0d channel splits with two long receiver stalls.",
                 items_sent, settings);
        $display("Compared %0d results: %0d void fills, %0d dropped, %0d failures.",
                 checked, void_fills, drops, errors);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
